>>> hw/rtl/aavr_pkg.sv
// Package for the axis-angle vector rotation unit: CORDIC constants,
// arctangent table and the word types passed along the pipeline.
// No dependencies.
package aavr_pkg;

  localparam int TrigIterations = 16;
  localparam int AtanSteps      = 30;
  localparam int NumCordic      = (TrigIterations > AtanSteps) ? AtanSteps : TrigIterations;
  localparam int IdxW           = (NumCordic > 1) ? $clog2(NumCordic) : 1;

  localparam logic signed [33:0] Deg90   = 34'sd5898240;
  localparam logic signed [33:0] Deg180  = 34'sd11796480;
  localparam logic signed [33:0] Deg360  = 34'sd23592960;
  localparam logic signed [33:0] CordicK = 34'sd652032874;

  // Pipeline depth: 5 angle-reduction stages, CORDIC cells, 6 arithmetic stages
  localparam int PreStages  = 5;
  localparam int PostStages = 6;
  localparam int Latency    = PreStages + NumCordic + PostStages;

  // round(atan(2^-i) * 180/pi * 65536)
  function automatic logic signed [33:0] atan_deg(input int i);
    logic signed [33:0] t;
    unique case (i)
      0: t = 34'sd2949120;   1: t = 34'sd1740967;  2: t = 34'sd919879;
      3: t = 34'sd466945;    4: t = 34'sd234379;   5: t = 34'sd117304;
      6: t = 34'sd58666;     7: t = 34'sd29335;    8: t = 34'sd14668;
      9: t = 34'sd7334;      10: t = 34'sd3667;    11: t = 34'sd1833;
      12: t = 34'sd917;      13: t = 34'sd458;     14: t = 34'sd229;
      15: t = 34'sd115;      16: t = 34'sd57;      17: t = 34'sd29;
      18: t = 34'sd14;       19: t = 34'sd7;       20: t = 34'sd4;
      21: t = 34'sd2;        22: t = 34'sd1;
      default: t = 34'sd0;
    endcase
    return t;
  endfunction

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } axis_t;

  // One CORDIC cell's state word
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic               neg;
  } cordic_t;

endpackage

>>> hw/rtl/aavr_cordic_cell.sv
// One rotation-mode CORDIC micro-rotation with a register on its output.
// Depends on aavr_pkg.
module aavr_cordic_cell (
  input  logic                clk,
  input  logic                en,
  input  logic [aavr_pkg::IdxW-1:0] idx,
  input  aavr_pkg::cordic_t   din,
  output aavr_pkg::cordic_t   dout
);
  import aavr_pkg::*;

  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [33:0] at;
  cordic_t            nxt;

  assign xs = din.x >>> idx;
  assign ys = din.y >>> idx;
  assign at = atan_deg(int'(idx));

  // rotate toward zero residual angle
  always_comb begin
    nxt = din;
    if (!din.z[33]) begin
      nxt.x = din.x - ys;
      nxt.y = din.y + xs;
      nxt.z = din.z - at;
    end else begin
      nxt.x = din.x + ys;
      nxt.y = din.y - xs;
      nxt.z = din.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (en) dout <= nxt;
  end
endmodule

>>> hw/rtl/aavr_trig.sv
// Angle reduction plus the chain of CORDIC cells; yields cos and sin in Q.26.
// Depends on aavr_pkg and aavr_cordic_cell.
module aavr_trig (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] angle,
  output logic signed [27:0] cos26,
  output logic signed [27:0] sin26
);
  import aavr_pkg::*;

  logic signed [33:0] r0, r1, r2;
  logic signed [33:0] r3;
  logic               n3;
  cordic_t            chain [NumCordic+1];
  logic signed [33:0] xo, yo;

  // reduce modulo 360: |angle / 360deg| < 2^7, so the turn count comes from
  // a reciprocal multiply, registered before the subtract
  logic signed [33:0] a_ext;
  logic signed [47:0] prod;
  logic signed [15:0] q;
  logic signed [33:0] a1;
  logic signed [15:0] q1;
  assign a_ext = 34'(angle);
  // q = floor(angle / Deg360) via reciprocal (2^40 / 23592960 ~= 46603.38)
  assign prod = 48'(a_ext) * 48'sd46604;
  assign q    = 16'(prod >>> 40);

  always_ff @(posedge clk) begin
    if (en) begin
      a1 <= a_ext;
      q1 <= q;
      r0 <= a1 - 34'(q1 * Deg360);
      // correction: reciprocal may be off by one
      if (r0 < 0)            r1 <= r0 + Deg360;
      else if (r0 >= Deg360) r1 <= r0 - Deg360;
      else                   r1 <= r0;
      r2 <= (r1 > Deg180) ? r1 - Deg360 : r1;
      if (r2 > Deg90) begin
        r3 <= r2 - Deg180; n3 <= 1'b1;
      end else if (r2 < -Deg90) begin
        r3 <= r2 + Deg180; n3 <= 1'b1;
      end else begin
        r3 <= r2; n3 <= 1'b0;
      end
    end
  end

  assign chain[0] = '{x: CordicK, y: 34'sd0, z: r3, neg: n3};

  // one cell per CORDIC step
  for (genvar i = 0; i < NumCordic; i++) begin : g_cell
    aavr_cordic_cell u_cell (
      .clk(clk), .en(en), .idx(IdxW'(i)), .din(chain[i]), .dout(chain[i+1])
    );
  end

  assign xo    = chain[NumCordic].x >>> 4;
  assign yo    = chain[NumCordic].y >>> 4;
  assign cos26 = chain[NumCordic].neg ? -28'(xo) : 28'(xo);
  assign sin26 = chain[NumCordic].neg ? -28'(yo) : 28'(yo);
endmodule

>>> hw/rtl/aavr_combine.sv
// Rodrigues combine: dot and cross products, scaling, rounding, saturation.
// Depends on aavr_pkg. Six register stages.
module aavr_combine (
  input  logic               clk,
  input  logic               en,
  input  aavr_pkg::vec_t     v,
  input  aavr_pkg::axis_t    k,
  input  logic signed [27:0] cos26,
  input  logic signed [27:0] sin26,
  output aavr_pkg::vec_t     rot,
  output logic               sat
);
  import aavr_pkg::*;

  // stage 1: products
  logic signed [47:0] p_kv [3];
  logic signed [47:0] p_cr [6];
  vec_t               v1, v2, v3;
  axis_t              k1, k2, k3, k4;
  logic signed [27:0] c1, s1, c2, s2, c3, s3;
  // stage 2: sums
  logic signed [49:0] dot2;
  logic signed [48:0] cr2 [3];
  // stage 3: shifted
  logic signed [35:0] dot3;
  logic signed [34:0] cr3 [3];
  logic signed [28:0] omc3;
  // stage 4: w and term products
  logic signed [64:0] w4;
  logic signed [59:0] vc4 [3];
  logic signed [62:0] cs4 [3];
  // stage 5
  logic signed [38:0] w5;
  logic signed [49:0] vc5 [3];
  logic signed [52:0] cs5 [3];
  logic signed [15:0] k5 [3];
  // stage 6
  logic signed [63:0] sum6 [3];
  logic signed [47:0] r6 [3];
  logic [2:0]         hi, lo;

  always_ff @(posedge clk) begin
    if (en) begin
      p_kv[0] <= v.x * k.x;  p_kv[1] <= v.y * k.y;  p_kv[2] <= v.z * k.z;
      p_cr[0] <= k.y * v.z;  p_cr[1] <= k.z * v.y;
      p_cr[2] <= k.z * v.x;  p_cr[3] <= k.x * v.z;
      p_cr[4] <= k.x * v.y;  p_cr[5] <= k.y * v.x;
      v1 <= v; k1 <= k; c1 <= cos26; s1 <= sin26;

      dot2 <= 50'(p_kv[0]) + 50'(p_kv[1]) + 50'(p_kv[2]);
      cr2[0] <= 49'(p_cr[0]) - 49'(p_cr[1]);
      cr2[1] <= 49'(p_cr[2]) - 49'(p_cr[3]);
      cr2[2] <= 49'(p_cr[4]) - 49'(p_cr[5]);
      v2 <= v1; k2 <= k1; c2 <= c1; s2 <= s1;

      dot3 <= 36'(dot2 >>> 14);
      for (int j = 0; j < 3; j++) cr3[j] <= 35'(cr2[j] >>> 14);
      omc3 <= 29'sd67108864 - 29'(c2);
      v3 <= v2; k3 <= k2; c3 <= c2; s3 <= s2;

      // w = dot * (1 - cos), plus the cos and sin terms
      w4 <= 65'(dot3) * 65'(omc3);
      vc4[0] <= 60'(v3.x) * 60'(c3);
      vc4[1] <= 60'(v3.y) * 60'(c3);
      vc4[2] <= 60'(v3.z) * 60'(c3);
      for (int j = 0; j < 3; j++) cs4[j] <= 63'(cr3[j]) * 63'(s3);
      k4 <= k3;

      w5 <= 39'(w4 >>> 26);
      for (int j = 0; j < 3; j++) begin
        vc5[j] <= 50'(vc4[j] >>> 10);
        cs5[j] <= 53'(cs4[j] >>> 10);
      end
      k5[0] <= k4.x; k5[1] <= k4.y; k5[2] <= k4.z;

      for (int j = 0; j < 3; j++)
        sum6[j] <= 64'(vc5[j]) + (64'(k5[j]) * 64'(w5) <<< 2) + 64'(cs5[j]) + 64'sd32768;
    end
  end

  // round and saturate
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      r6[j] = 48'(sum6[j] >>> 16);
      hi[j] = r6[j] > 48'sh7fffffff;
      lo[j] = r6[j] < -48'sh80000000;
    end
  end

  assign rot.x = hi[0] ? 32'sh7fffffff : lo[0] ? 32'sh80000000 : 32'(r6[0]);
  assign rot.y = hi[1] ? 32'sh7fffffff : lo[1] ? 32'sh80000000 : 32'(r6[1]);
  assign rot.z = hi[2] ? 32'sh7fffffff : lo[2] ? 32'sh80000000 : 32'(r6[2]);
  assign sat   = |(hi | lo);
endmodule

>>> hw/rtl/axis_angle_vector_rotate_unit.sv
// Axis-angle vector rotation unit (Rodrigues), top level.
// Depends on aavr_pkg, aavr_trig, aavr_combine.
//
// Input stream s_axis: one word holds vector, unit axis and angle in degrees.
// Output stream m_axis: one word holds the rotated vector and a clip flag.
// A new word is taken every cycle while the pipeline is not frozen. The path
// runs through 5 angle reduction stages, one CORDIC cell per iteration, 6
// arithmetic stages and one output register.
// The whole pipeline advances together; when m_axis_tready is low, the output
// register holds a word and the last stage holds a word too, the pipeline
// freezes and s_axis_tready drops. A word sitting in the output register does
// not block the pipeline while the next word is still in flight.
// Reset clears the valid tags of every stage and the output register; data
// registers are not reset.
// tdata packing is as listed beside each port; cos/sin are generated by
// the CORDIC chain with fixed gain.
//
module axis_angle_vector_rotate_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // vec_x[31:0], vec_y[63:32], vec_z[95:64], axis_x[111:96],
  // axis_y[127:112], axis_z[143:128], angle_deg[175:144]
  input  logic [175:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // rot_x[31:0], rot_y[63:32], rot_z[95:64], saturated[96], zero pad
  output logic [103:0] m_axis_tdata
);
  import aavr_pkg::*;

  logic                 en;
  logic                 out_free;
  logic [Latency-1:0]   vld;
  vec_t                 vin, vdl;
  axis_t                kin, kdl;
  logic signed [27:0]   c26, s26;
  vec_t                 rot;
  logic                 sat;
  vec_t                 vq [PreStages+NumCordic];
  axis_t                kq [PreStages+NumCordic];

  assign vin = '{x: s_axis_tdata[31:0], y: s_axis_tdata[63:32], z: s_axis_tdata[95:64]};
  assign kin = '{x: s_axis_tdata[111:96], y: s_axis_tdata[127:112],
                 z: s_axis_tdata[143:128]};

  // advance when output slot is free or will be emptied, or last stage is empty
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign en            = out_free || !vld[Latency-1];
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Latency-2:0], s_axis_tvalid};
    end
  end

  // delay line for vector and axis alongside the trig chain
  always_ff @(posedge clk) begin
    if (en) begin
      vq[0] <= vin; kq[0] <= kin;
      for (int i = 1; i < PreStages + NumCordic; i++) begin
        vq[i] <= vq[i-1]; kq[i] <= kq[i-1];
      end
    end
  end
  assign vdl = vq[PreStages+NumCordic-1];
  assign kdl = kq[PreStages+NumCordic-1];

  aavr_trig u_trig (
    .clk(clk), .en(en), .angle(s_axis_tdata[175:144]), .cos26(c26), .sin26(s26)
  );

  aavr_combine u_comb (
    .clk(clk), .en(en), .v(vdl), .k(kdl), .cos26(c26), .sin26(s26),
    .rot(rot), .sat(sat)
  );

  // output register: loads only when its word is gone or taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= vld[Latency-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && vld[Latency-1]) begin
      m_axis_tdata <= {7'd0, sat, rot.z, rot.y, rot.x};
    end
  end

  // held output word stays put under backpressure
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  // pipeline only freezes with a full, stalled output
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  // a frozen pipeline keeps its valid tags
  a_tags: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("stage valid tags moved during stall");
endmodule
